// ===== hdl/md5_pkg.sv =====
// md5 digest engine shared package: constants, queue entry type, round tables
// no dependencies
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  // queue entry from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } md5_item_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/md5_front.sv =====
// md5 front end: takes input beats, drops empty ones, queues the rest
// depends on md5_pkg
module md5_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             s_axis_tlast,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output md5_pkg::md5_item_t q_item_o
);

  md5_pkg::md5_item_t         mem_q [md5_pkg::QDepth];
  logic [md5_pkg::QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [md5_pkg::QPtrW:0]    cnt_q, cnt_d;
  logic                       push;

  assign s_axis_tready = (cnt_q < (md5_pkg::QPtrW+1)'(md5_pkg::QDepth));
  // beats with neither byte nor last do nothing
  assign push = s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast);
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = q_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (md5_pkg::QPtrW+1)'(push) - (md5_pkg::QPtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
                       last: s_axis_tlast};
    end
  end

endmodule

// ===== hdl/md5_back.sv =====
// md5 back end: byte packing, padding sequencer, one round per cycle, output reg
// depends on md5_pkg
module md5_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  md5_pkg::md5_item_t q_item_i,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [127:0]       m_axis_tdata
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StComp = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StZero = 3'd6;

  logic [2:0]  st_q, st_d, ret_q, ret_d;
  logic [31:0] blk_q [16];
  logic [31:0] ha_q, hb_q, hc_q, hd_q;
  logic [31:0] ra_q, rb_q, rc_q, rd_q;
  logic [5:0]  rnd_q, pos_q;
  logic [63:0] bits_q, len_q;
  logic        ovalid_q;
  logic [127:0] odata_q;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [3:0]  g;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;
  logic        out_load;

  // message word index and round function
  always_comb begin
    case (rnd_q[5:4])
      2'd0: begin f = (rb_q & rc_q) | (~rb_q & rd_q); g = rnd_q[3:0]; end
      2'd1: begin
        f = (rd_q & rb_q) | (~rd_q & rc_q);
        g = 4'(rnd_q * 3'd5 + 1'b1);
      end
      2'd2: begin f = rb_q ^ rc_q ^ rd_q; g = 4'(rnd_q * 2'd3 + 3'd5); end
      default: begin f = rc_q ^ (rb_q | ~rd_q); g = 4'(rnd_q * 3'd7); end
    endcase
    sh  = md5_pkg::rot_amt(rnd_q);
    sum = ra_q + f + md5_pkg::sine_k(rnd_q) + blk_q[g];
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  // sequencer: one byte per cycle into the block while no block is compressed and bytes are queued, 64 rounds per block
  always_comb begin
    st_d    = st_q;
    ret_d   = ret_q;
    q_pop_o = 1'b0;
    wr_en   = 1'b0;
    wr_byte = q_item_i.data_byte;
    case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.has_byte) begin
            wr_en = 1'b1;
            if (pos_q == 6'd63) begin
              st_d  = StComp;
              ret_d = q_item_i.last ? StPad : StIdle;
            end else if (q_item_i.last) begin
              st_d = StPad;
            end
          end else begin
            st_d = StPad;
          end
        end
      end
      StPad: begin
        wr_en   = 1'b1;
        wr_byte = md5_pkg::PadByte;
        if (pos_q == 6'd63) begin
          st_d = StComp; ret_d = StLen;
        end else if (pos_q > 6'd55) st_d = StZero;
        else st_d = StLen;
      end
      // no room for the length: zero the rest of this block
      StZero: begin
        wr_en   = 1'b1;
        wr_byte = 8'h00;
        if (pos_q == 6'd63) begin
          st_d = StComp; ret_d = StLen;
        end
      end
      StLen: begin
        wr_en   = 1'b1;
        wr_byte = (pos_q < 6'd56) ? 8'h00 : len_q[8*pos_q[2:0] +: 8];
        if (pos_q == 6'd63) begin
          st_d = StComp; ret_d = StOut;
        end
      end
      StComp: if (rnd_q == 6'd63) st_d = StAdd;
      StAdd: st_d = ret_q;
      StOut: if (!ovalid_q || m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign out_load = (st_q == StOut) && (!ovalid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ret_q <= StIdle;
      ha_q <= md5_pkg::InitA; hb_q <= md5_pkg::InitB;
      hc_q <= md5_pkg::InitC; hd_q <= md5_pkg::InitD;
      ra_q <= '0; rb_q <= '0; rc_q <= '0; rd_q <= '0;
      rnd_q <= '0; pos_q <= '0; bits_q <= '0; len_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (wr_en) begin
        pos_q <= pos_q + 1'b1;
        if (pos_q == 6'd63) begin
          ra_q <= ha_q; rb_q <= hb_q; rc_q <= hc_q; rd_q <= hd_q;
        end
      end
      if (st_q == StIdle && q_pop_o) begin
        if (q_item_i.has_byte) begin
          bits_q <= bits_q + 64'd8;
          len_q  <= bits_q + 64'd8;
        end else begin
          len_q <= bits_q;
        end
      end
      if (st_q == StComp) begin
        ra_q <= rd_q; rd_q <= rc_q; rc_q <= rb_q; rb_q <= rb_q + rot;
        rnd_q <= rnd_q + 1'b1;
      end
      if (st_q == StAdd) begin
        ha_q <= ha_q + ra_q; hb_q <= hb_q + rb_q;
        hc_q <= hc_q + rc_q; hd_q <= hd_q + rd_q;
      end
      // digest out and engine back to reset state
      if (out_load) begin
        ha_q <= md5_pkg::InitA; hb_q <= md5_pkg::InitB;
        hc_q <= md5_pkg::InitC; hd_q <= md5_pkg::InitD;
        ra_q <= '0; rb_q <= '0; rc_q <= '0; rd_q <= '0;
        pos_q <= '0; bits_q <= '0;
      end
    end
  end

  // block buffer write, little-endian bytes
  always_ff @(posedge clk_i) begin
    if (wr_en) blk_q[pos_q[5:2]][8*pos_q[1:0] +: 8] <= wr_byte;
    if (out_load)
      odata_q <= {hd_q, hc_q, hb_q, ha_q};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

// ===== hdl/md5_digest_engine.sv =====
// md5 digest engine top level: front queue plus back compression sequencer
// depends on md5_pkg, md5_front, md5_back
//
// usage: stream a message one byte per slave beat (tuser = byte present,
// tlast = end of message). a beat with tlast and no byte closes the
// message as it stands; a beat with neither is dropped.
// the master channel gives one beat per message holding digest a..d.
// each byte is written into the block by the back end; each full block
// then takes 64 rounds plus one add step.
// the last beat adds padding writes (spilling into a second block when
// the length does not fit), the rounds for one or two blocks and a load
// of the output register before the digest is shown.
// the round loop, one md5 round per cycle, sets the rate.
// a two-entry queue parts the input from the sequencer, so beats are
// taken while a block is compressed until the queue fills.
// reset clears the chaining values to the md5 initial constants.
// when the receiver stalls, the digest waits in the output register and
// the next message may still queue up at the input.
module md5_digest_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // has_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_a, digest_b, digest_c, digest_d
);

  logic               q_valid, q_pop;
  md5_pkg::md5_item_t q_item;

  md5_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .s_axis_tlast,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  md5_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // never pop an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest changed under stall");

endmodule

// ===== dv/tb_md5_digest_engine.sv =====
// testbench for md5_digest_engine: streams byte messages, checks each digest beat
// depends on md5_pkg and the md5_digest_engine rtl
`timescale 1ns / 100ps

module tb_md5_digest_engine;

  typedef struct {
    logic [31:0] a, b, c, d;
  } digest_t;

  // digest scoreboard: predicts md5 of the byte stream and checks results
  class digest_scoreboard;
    logic [31:0] words[16];
    logic [31:0] chain[4];
    logic [5:0]  pos;
    logic [63:0] nbits;
    digest_t     pending[$];
    int          errors;

    function new();
      foreach (words[i]) words[i] = '0;
      restart();
      errors = 0;
    endfunction

    function void restart();
      chain[0] = md5_pkg::InitA; chain[1] = md5_pkg::InitB;
      chain[2] = md5_pkg::InitC; chain[3] = md5_pkg::InitD;
      pos = '0;
      nbits = '0;
    endfunction

    function void compress();
      logic [31:0] ra, rb, rc, rd, f, t;
      logic [5:0] g;
      ra = chain[0]; rb = chain[1]; rc = chain[2]; rd = chain[3];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          f = (rb & rc) | (~rb & rd); g = 6'(r);
        end else if (r < 32) begin
          f = (rd & rb) | (~rd & rc); g = 6'((5 * r + 1) % 16);
        end else if (r < 48) begin
          f = rb ^ rc ^ rd; g = 6'((3 * r + 5) % 16);
        end else begin
          f = rc ^ (rb | ~rd); g = 6'((7 * r) % 16);
        end
        t = ra + f + sine_const(r) + words[g[3:0]];
        ra = rd; rd = rc; rc = rb;
        rb = rb + ((t << shift_of(r)) | (t >> (32 - shift_of(r))));
      end
      chain[0] += ra; chain[1] += rb; chain[2] += rc; chain[3] += rd;
    endfunction

    function int shift_of(int r);
      int s[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      return s[(r / 16) * 4 + r % 4];
    endfunction

    function logic [31:0] sine_const(int r);
      logic [31:0] k[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
        32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
        32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
        32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
        32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
        32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[r];
    endfunction

    function void put_byte(logic [7:0] v);
      words[pos[5:2]][pos[1:0]*8 +: 8] = v;
      pos = pos + 1;
      if (pos == 0) compress();
    endfunction

    // note one accepted input beat
    function void note_input(logic [7:0] data, logic has, logic fin);
      logic [63:0] len;
      digest_t dg;
      if (has) begin
        put_byte(data);
        nbits += 64'd8;
      end
      if (!fin) return;
      len = nbits;
      put_byte(md5_pkg::PadByte);
      while (pos != 6'd56) put_byte(8'h00);
      for (int i = 0; i < 8; i++) put_byte(len[8*i +: 8]);
      dg.a = chain[0]; dg.b = chain[1]; dg.c = chain[2]; dg.d = chain[3];
      pending.push_back(dg);
      restart();
    endfunction

    task report(string line);
      $display("mismatch %s", line);
      errors++;
    endtask

    // check one digest beat against the oldest prediction
    task check_digest(logic [127:0] data);
      digest_t dg;
      if (pending.size() == 0) begin
        report($sformatf("digest beat %032h with none expected", data));
        return;
      end
      dg = pending.pop_front();
      if (data[31:0] !== dg.a)
        report($sformatf("digest_a: got %08h expected %08h", data[31:0], dg.a));
      if (data[63:32] !== dg.b)
        report($sformatf("digest_b: got %08h expected %08h", data[63:32], dg.b));
      if (data[95:64] !== dg.c)
        report($sformatf("digest_c: got %08h expected %08h", data[95:64], dg.c));
      if (data[127:96] !== dg.d)
        report($sformatf("digest_d: got %08h expected %08h", data[127:96], dg.d));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  digest_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          stim_done = 1'b0;

  localparam int unsigned CycleLimit = 1_000_000;

  md5_digest_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // receiver stall pattern, checks on each digest beat
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_digest(m_axis_tdata);
    case (cycles % 200 < 60 ? 0 : 1)
      0: m_axis_tready <= 1'b1;
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // send one beat, with bursty gaps before it
  task automatic send_beat(logic [7:0] data, logic has, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(data, has, fin);
  endtask

  task automatic send_message(int unsigned len, int unsigned mode);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = 8'h00;
        1: v = 8'hff;
        default: v = 8'($urandom_range(0, 255));
      endcase
      // occasional byteless beat mid message is dropped by the block
      if ($urandom_range(0, 30) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(0, 1)) begin
        send_beat(v, 1'b1, 1'b1);
        return;
      end
      send_beat(v, 1'b1, 1'b0);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned lens[$];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, a dropped byteless beat, short messages, block boundaries around the length field
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'h61, 1'b1, 1'b1);
    send_message(3, 1);
    send_message(7, 0);
    drain();
    lens = '{55, 56, 63, 64, 65, 119, 120};
    foreach (lens[i]) send_message(lens[i], i % 3);
    drain();

    // random short messages
    for (int n = 0; n < 24; n++) begin
      send_message($urandom_range(0, 14), 2);
      if (n == 12) drain();
    end
    drain();
    stim_done = 1'b1;
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
